/* hdl/sauv_pkg.sv */
// Shared constants and codes for the Sauvola local threshold unit.
package sauv_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_OUTSIDE    = 2'd1;
    localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

    localparam logic [7:0] WINDOW_RESET = 8'd40;
    localparam logic [9:0] K_RESET      = 10'd307;
    localparam int         SIZE_RESET   = 256;

    localparam logic [7:0] PIX_BLACK = 8'd0;
    localparam logic [7:0] PIX_WHITE = 8'd255;

    // 1.0 in the Q2.25 threshold factor, and the k*1.0 term weight
    localparam logic [26:0] F_ONE = 27'd33554432;

endpackage

/* hdl/sauv_if.sv */
// Channel interfaces: input items, result items and configuration writes.
interface sauv_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] pixel_value;
    logic [7:0] query_row;
    logic [7:0] query_col;

    modport source (output valid, cmd, pixel_value, query_row, query_col, input ready);
    modport sink   (input valid, cmd, pixel_value, query_row, query_col, output ready);
endinterface

interface sauv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] binary_value;
    logic [1:0] status;

    modport source (output valid, binary_value, status, input ready);
    modport sink   (input valid, binary_value, status, output ready);
endinterface

interface sauv_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sauv_pkg::CFG_IDX_W-1:0]   index;
    logic [sauv_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/sauv_div.sv */
// Restoring divider, one quotient bit per cycle, 64 by 32 with 32-bit quotient.
module sauv_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);
    import sauv_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            // upper half is below the divisor, so 32 steps suffice
            rem_next  = dividend[63:32];
            quo_next  = dividend[31:0];
            den_next  = divisor;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/sauv_sqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle.
module sauv_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] radicand,
    output logic        done,
    output logic [15:0] root
);
    import sauv_pkg::*;

    logic [31:0] v_reg, v_next;
    logic [31:0] root_reg, root_next;
    logic [31:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] trial;

    always_comb
    begin
        v_next    = v_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = root_reg + bit_reg;
        if (start)
        begin
            v_next    = radicand;
            root_next = 32'd0;
            bit_next  = 32'h4000_0000;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next    = v_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 32'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = root_reg[15:0];

endmodule

/* hdl/sauvola_local_threshold_unit.sv */
// Top level of the Sauvola local threshold unit with integral image memory.
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  in_ch    | in  | cmd, pixel_value, query_row, query_col    | valid/ready
//  out_ch   | out | binary_value, status                      | valid/ready
//  cfg_ch   | in  | index, data                               | valid/ready
//
//  A load transaction goes through accept, read of the entry above and write back.
//  A full query reads four corners and the pixel on the single read port, runs the
//  shared divider for the mean and, for a window over one pixel, for the variance
//  and a square root. Queries outside the image or before the frame is complete
//  go straight to ST_OUT. After reset the memory holds no data; no clearing pass
//  runs. A pending result waits in the output register; loads keep flowing
//  meanwhile, and a finished query holds in place only while that register is full.
module sauvola_local_threshold_unit
#(
    parameter int MAX_WIDTH  = sauv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sauv_pkg::DEF_MAX_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    sauv_in_if.sink    in_ch,
    sauv_out_if.source out_ch,
    sauv_cfg_if.sink   cfg_ch
);
    import sauv_pkg::*;

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int AW     = XW + YW;
    localparam int DEPTH  = 1 << AW;
    localparam int VW     = AW + 8;
    localparam int QW     = AW + 16;
    localparam int RSW    = XW + 8;
    localparam int RQW    = XW + 16;
    localparam int WORD_W = 8 + VW + QW;
    localparam int EWW    = XW + 1;
    localparam int EHW    = YW + 1;
    localparam int EW_RST = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
    localparam int EH_RST = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LD_RD = 4'd1;
    localparam logic [3:0] ST_LD_WR = 4'd2;
    localparam logic [3:0] ST_Q_CHK = 4'd3;
    localparam logic [3:0] ST_Q_RD  = 4'd4;
    localparam logic [3:0] ST_Q_M1  = 4'd5;
    localparam logic [3:0] ST_Q_M2  = 4'd6;
    localparam logic [3:0] ST_DIVM  = 4'd7;
    localparam logic [3:0] ST_DVS   = 4'd8;
    localparam logic [3:0] ST_DIVV  = 4'd9;
    localparam logic [3:0] ST_SQ    = 4'd10;
    localparam logic [3:0] ST_F1    = 4'd11;
    localparam logic [3:0] ST_F2    = 4'd12;
    localparam logic [3:0] ST_F3    = 4'd13;
    localparam logic [3:0] ST_CMP   = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    // control state
    logic [3:0]     state_reg, state_next;
    logic [7:0]     win_reg, win_next;
    logic [9:0]     k_reg, k_next;
    logic [EWW-1:0] ew_reg, ew_next;
    logic [EHW-1:0] eh_reg, eh_next;
    logic           fc_reg, fc_next;
    logic [XW-1:0]  pos_col_reg, pos_col_next;
    logic [YW-1:0]  pos_row_reg, pos_row_next;
    logic [RSW-1:0] rsum_reg, rsum_next;
    logic [RQW-1:0] rsq_reg, rsq_next;
    logic [2:0]     cnt_reg, cnt_next;
    logic           out_vld_reg, out_vld_next;

    // payload
    logic [XW-1:0]  it_col_reg, it_col_next;
    logic [YW-1:0]  it_row_reg, it_row_next;
    logic [7:0]     pix_in_reg, pix_in_next;
    logic [7:0]     q_row_reg, q_row_next;
    logic [7:0]     q_col_reg, q_col_next;
    logic [XW-1:0]  x0_reg, x0_next, x1_reg, x1_next;
    logic [YW-1:0]  y0_reg, y0_next, y1_reg, y1_next;
    logic [15:0]    area_reg, area_next;
    logic [VW-1:0]  sacc_reg, sacc_next;
    logic [QW-1:0]  qacc_reg, qacc_next;
    logic [7:0]     qpix_reg, qpix_next;
    logic [47:0]    prod_aq_reg, prod_aq_next;
    logic [47:0]    prod_ss_reg, prod_ss_next;
    logic [31:0]    den_reg, den_next;
    logic [47:0]    num_reg, num_next;
    logic [15:0]    mq_reg, mq_next;
    logic [15:0]    sq_reg, sq_next;
    logic [25:0]    ksq_reg, ksq_next;
    logic [26:0]    f_reg, f_next;
    logic [42:0]    prod_reg, prod_next;
    logic [7:0]     res_bin_reg, res_bin_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic [7:0]     out_bin_reg, out_bin_next;
    logic [1:0]     out_status_reg, out_status_next;

    // memory: {pixel, value integral, square integral}
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] mem_q;
    logic [WORD_W-1:0] mem_wd;
    logic [AW-1:0]     mem_ra;
    logic [AW-1:0]     mem_wa;
    logic              mem_we;
    logic [YW-1:0]     rd_row;
    logic [XW-1:0]     rd_col;
    logic [7:0]        mem_pix;
    logic [VW-1:0]     mem_v;
    logic [QW-1:0]     mem_sq;

    // arithmetic units
    logic        div_start, div_busy, div_done;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor, div_quot;
    logic        sqrt_start, sqrt_done;
    logic [15:0] sqrt_root;

    logic        in_acc;
    logic        cfg_acc;
    logic [23:0] s_win;
    logic [31:0] q_win;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
    assign s_win   = 24'(sacc_reg);
    assign q_win   = 32'(qacc_reg);

    assign mem_pix = mem_q[WORD_W-1 -: 8];
    assign mem_v   = mem_q[VW+QW-1 -: VW];
    assign mem_sq  = mem_q[QW-1:0];

    // read address: entry above for loads, window corners then the pixel for queries
    always_comb
    begin
        rd_row = it_row_reg - YW'(1);
        rd_col = it_col_reg;
        if (state_reg == ST_Q_RD)
        begin
            case (cnt_reg)
                3'd0:    begin rd_row = y1_reg;          rd_col = x1_reg;          end
                3'd1:    begin rd_row = y0_reg - YW'(1); rd_col = x1_reg;          end
                3'd2:    begin rd_row = y1_reg;          rd_col = x0_reg - XW'(1); end
                3'd3:    begin rd_row = y0_reg - YW'(1); rd_col = x0_reg - XW'(1); end
                default: begin rd_row = YW'(q_row_reg);  rd_col = XW'(q_col_reg);  end
            endcase
        end
        mem_ra = {rd_row, rd_col};
    end

    // write back the new integral entry
    always_comb
    begin
        logic [VW-1:0] above_v;
        logic [QW-1:0] above_q;
        above_v = (it_row_reg == '0) ? '0 : mem_v;
        above_q = (it_row_reg == '0) ? '0 : mem_sq;
        mem_we  = (state_reg == ST_LD_WR);
        mem_wa  = {it_row_reg, it_col_reg};
        mem_wd  = {pix_in_reg, above_v + VW'(rsum_reg), above_q + QW'(rsq_reg)};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q <= mem[mem_ra];
    end

    assign div_start    = (state_reg == ST_Q_M2) || (state_reg == ST_DVS);
    assign div_dividend = (state_reg == ST_DVS) ? {num_reg, 16'd0} : {32'd0, s_win, 8'd0};
    assign div_divisor  = (state_reg == ST_DVS) ? den_reg : {16'd0, area_reg};
    assign sqrt_start   = (state_reg == ST_DIVV) && div_done;

    sauv_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    sauv_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_quot),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        logic [XW-1:0] lcol;
        logic [YW-1:0] lrow;
        logic          last_col;
        logic [6:0]    half;
        int            xe, ye, xl, yl;
        logic [7:0]    wx, wy;

        state_next      = state_reg;
        win_next        = win_reg;
        k_next          = k_reg;
        ew_next         = ew_reg;
        eh_next         = eh_reg;
        fc_next         = fc_reg;
        pos_col_next    = pos_col_reg;
        pos_row_next    = pos_row_reg;
        rsum_next       = rsum_reg;
        rsq_next        = rsq_reg;
        cnt_next        = cnt_reg;
        out_vld_next    = out_vld_reg;
        it_col_next     = it_col_reg;
        it_row_next     = it_row_reg;
        pix_in_next     = pix_in_reg;
        q_row_next      = q_row_reg;
        q_col_next      = q_col_reg;
        x0_next         = x0_reg;
        x1_next         = x1_reg;
        y0_next         = y0_reg;
        y1_next         = y1_reg;
        area_next       = area_reg;
        sacc_next       = sacc_reg;
        qacc_next       = qacc_reg;
        qpix_next       = qpix_reg;
        prod_aq_next    = prod_aq_reg;
        prod_ss_next    = prod_ss_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        mq_next         = mq_reg;
        sq_next         = sq_reg;
        ksq_next        = ksq_reg;
        f_next          = f_reg;
        prod_next       = prod_reg;
        res_bin_next    = res_bin_reg;
        res_status_next = res_status_reg;
        out_bin_next    = out_bin_reg;
        out_status_next = out_status_reg;

        lcol     = fc_reg ? '0 : pos_col_reg;
        lrow     = fc_reg ? '0 : pos_row_reg;
        last_col = (int'(it_col_reg) + 1) == int'(ew_reg);
        half     = win_reg[7:1];
        xe       = int'(q_col_reg) + int'(half);
        ye       = int'(q_row_reg) + int'(half);
        xl       = int'(ew_reg) - 1;
        yl       = int'(eh_reg) - 1;
        wx       = 8'(int'(x1_reg) - int'(x0_reg) + 1);
        wy       = 8'(int'(y1_reg) - int'(y0_reg) + 1);

        // drop the result once the sink takes it
        if (out_vld_reg && out_ch.ready)
        begin
            out_vld_next = 1'b0;
        end

        if (cfg_acc)
        begin
            unique case (cfg_ch.index)
                REG_WINDOW: win_next = cfg_ch.data[7:0];
                REG_K:      k_next = cfg_ch.data;
                REG_WIDTH,
                REG_HEIGHT:
                begin
                    if (cfg_ch.index == REG_WIDTH)
                    begin
                        if (cfg_ch.data[8:0] == 9'd0)
                            ew_next = EWW'(1);
                        else if (int'(cfg_ch.data[8:0]) > MAX_WIDTH)
                            ew_next = EWW'(MAX_WIDTH);
                        else
                            ew_next = EWW'(cfg_ch.data[8:0]);
                    end
                    else
                    begin
                        if (cfg_ch.data[8:0] == 9'd0)
                            eh_next = EHW'(1);
                        else if (int'(cfg_ch.data[8:0]) > MAX_HEIGHT)
                            eh_next = EHW'(MAX_HEIGHT);
                        else
                            eh_next = EHW'(cfg_ch.data[8:0]);
                    end
                    // restart the frame load
                    pos_col_next = '0;
                    pos_row_next = '0;
                    rsum_next    = '0;
                    rsq_next     = '0;
                    fc_next      = 1'b0;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.cmd == CMD_LOAD)
                    begin
                        // a load after a finished frame starts a new one
                        fc_next     = 1'b0;
                        it_col_next = lcol;
                        it_row_next = lrow;
                        pix_in_next = in_ch.pixel_value;
                        rsum_next   = ((lcol == '0) ? '0 : rsum_reg) + RSW'(in_ch.pixel_value);
                        rsq_next    = ((lcol == '0) ? '0 : rsq_reg)
                                      + RQW'(16'(in_ch.pixel_value) * 16'(in_ch.pixel_value));
                        state_next  = ST_LD_RD;
                    end
                    else
                    begin
                        q_row_next = in_ch.query_row;
                        q_col_next = in_ch.query_col;
                        state_next = ST_Q_CHK;
                    end
                end
            end
            ST_LD_RD:
            begin
                state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                if (last_col)
                begin
                    pos_col_next = '0;
                    pos_row_next = it_row_reg + YW'(1);
                    if ((int'(it_row_reg) + 1) == int'(eh_reg))
                    begin
                        fc_next = 1'b1;
                    end
                end
                else
                begin
                    pos_col_next = it_col_reg + XW'(1);
                    pos_row_next = it_row_reg;
                end
                state_next = ST_IDLE;
            end
            ST_Q_CHK:
            begin
                res_bin_next = PIX_BLACK;
                if (int'(q_row_reg) >= int'(eh_reg) || int'(q_col_reg) >= int'(ew_reg))
                begin
                    res_status_next = STATUS_OUTSIDE;
                    state_next      = ST_OUT;
                end
                else if (!fc_reg)
                begin
                    res_status_next = STATUS_NOT_LOADED;
                    state_next      = ST_OUT;
                end
                else
                begin
                    // clip the window at the image edges
                    x0_next    = (q_col_reg > 8'(half)) ? XW'(q_col_reg - 8'(half)) : '0;
                    y0_next    = (q_row_reg > 8'(half)) ? YW'(q_row_reg - 8'(half)) : '0;
                    x1_next    = (xe < xl) ? XW'(xe) : XW'(xl);
                    y1_next    = (ye < yl) ? YW'(ye) : YW'(yl);
                    cnt_next   = 3'd0;
                    state_next = ST_Q_RD;
                end
            end
            ST_Q_RD:
            begin
                if (cnt_reg == 3'd0)
                begin
                    area_next = 16'(wx) * 16'(wy);
                end
                // read data is registered and arrives in the cycle after its address
                case (cnt_reg)
                    3'd1:
                    begin
                        sacc_next = mem_v;
                        qacc_next = mem_sq;
                    end
                    3'd2:
                    begin
                        if (y0_reg != '0)
                        begin
                            sacc_next = sacc_reg - mem_v;
                            qacc_next = qacc_reg - mem_sq;
                        end
                    end
                    3'd3:
                    begin
                        if (x0_reg != '0)
                        begin
                            sacc_next = sacc_reg - mem_v;
                            qacc_next = qacc_reg - mem_sq;
                        end
                    end
                    3'd4:
                    begin
                        if (x0_reg != '0 && y0_reg != '0)
                        begin
                            sacc_next = sacc_reg + mem_v;
                            qacc_next = qacc_reg + mem_sq;
                        end
                    end
                    3'd5:
                    begin
                        qpix_next = mem_pix;
                    end
                    default: ;
                endcase
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    state_next = ST_Q_M1;
                end
            end
            ST_Q_M1:
            begin
                prod_aq_next = 48'(area_reg) * 48'(q_win);
                prod_ss_next = 48'(s_win) * 48'(s_win);
                den_next     = 32'(area_reg) * 32'(area_reg - 16'd1);
                state_next   = ST_Q_M2;
            end
            ST_Q_M2:
            begin
                // mean division starts here
                num_next   = prod_aq_reg - prod_ss_reg;
                state_next = ST_DIVM;
            end
            ST_DIVM:
            begin
                if (div_done)
                begin
                    mq_next = div_quot[15:0];
                    if (area_reg == 16'd1)
                    begin
                        sq_next    = 16'd0;
                        state_next = ST_F1;
                    end
                    else
                    begin
                        state_next = ST_DVS;
                    end
                end
            end
            ST_DVS:
            begin
                state_next = ST_DIVV;
            end
            ST_DIVV:
            begin
                if (div_done)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (sqrt_done)
                begin
                    sq_next    = sqrt_root;
                    state_next = ST_F1;
                end
            end
            ST_F1:
            begin
                ksq_next   = 26'(k_reg) * 26'(sq_reg);
                state_next = ST_F2;
            end
            ST_F2:
            begin
                f_next     = F_ONE - {2'd0, k_reg, 15'd0} + 27'(ksq_reg);
                state_next = ST_F3;
            end
            ST_F3:
            begin
                prod_next  = 43'(mq_reg) * 43'(f_reg);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                res_status_next = STATUS_OK;
                res_bin_next    = ({2'd0, qpix_reg, 33'd0} < prod_reg) ? PIX_BLACK : PIX_WHITE;
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_vld_reg || out_ch.ready)
                begin
                    out_vld_next    = 1'b1;
                    out_bin_next    = res_bin_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            win_reg     <= WINDOW_RESET;
            k_reg       <= K_RESET;
            ew_reg      <= EWW'(EW_RST);
            eh_reg      <= EHW'(EH_RST);
            fc_reg      <= 1'b0;
            pos_col_reg <= '0;
            pos_row_reg <= '0;
            rsum_reg    <= '0;
            rsq_reg     <= '0;
            cnt_reg     <= 3'd0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            win_reg     <= win_next;
            k_reg       <= k_next;
            ew_reg      <= ew_next;
            eh_reg      <= eh_next;
            fc_reg      <= fc_next;
            pos_col_reg <= pos_col_next;
            pos_row_reg <= pos_row_next;
            rsum_reg    <= rsum_next;
            rsq_reg     <= rsq_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_col_reg     <= it_col_next;
        it_row_reg     <= it_row_next;
        pix_in_reg     <= pix_in_next;
        q_row_reg      <= q_row_next;
        q_col_reg      <= q_col_next;
        x0_reg         <= x0_next;
        x1_reg         <= x1_next;
        y0_reg         <= y0_next;
        y1_reg         <= y1_next;
        area_reg       <= area_next;
        sacc_reg       <= sacc_next;
        qacc_reg       <= qacc_next;
        qpix_reg       <= qpix_next;
        prod_aq_reg    <= prod_aq_next;
        prod_ss_reg    <= prod_ss_next;
        den_reg        <= den_next;
        num_reg        <= num_next;
        mq_reg         <= mq_next;
        sq_reg         <= sq_next;
        ksq_reg        <= ksq_next;
        f_reg          <= f_next;
        prod_reg       <= prod_next;
        res_bin_reg    <= res_bin_next;
        res_status_reg <= res_status_next;
        out_bin_reg    <= out_bin_next;
        out_status_reg <= out_status_next;
    end

    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign cfg_ch.ready        = 1'b1;
    assign out_ch.valid        = out_vld_reg;
    assign out_ch.binary_value = out_bin_reg;
    assign out_ch.status       = out_status_reg;

    a_bin_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_bin_reg == PIX_BLACK || out_bin_reg == PIX_WHITE))
        else $error("result is neither black nor white");

    a_error_black: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_status_reg != STATUS_OK) |-> out_bin_reg == PIX_BLACK)
        else $error("error status with white result");

    a_frame_done_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fc_reg) |-> $past(state_reg) == ST_LD_WR)
        else $error("frame completed without a load write");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

/* test/sauvola_local_threshold_unit_tb.sv */
// Self-checking testbench for the Sauvola local threshold unit.
`timescale 1ns / 100ps

module sauvola_local_threshold_unit_tb;
    import sauv_pkg::*;

    localparam int MAXW        = DEF_MAX_WIDTH;
    localparam int MAXH        = DEF_MAX_HEIGHT;
    localparam int SETTLE      = 150;     // covers one full query plus slack
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [7:0] binary_value;
        logic [1:0] status;
    } pixel_verdict_t;

    logic clk;
    logic rst_n;

    sauv_in_if  in_ch ();
    sauv_out_if out_ch ();
    sauv_cfg_if cfg_ch ();

    sauvola_local_threshold_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Shadow copy of the block: frame memories, running sums and registers.
    bit [7:0]  shadow_pixels   [MAXW*MAXH];
    bit [23:0] shadow_sum_img  [MAXW*MAXH];
    bit [31:0] shadow_sq_img   [MAXW*MAXH];
    bit [15:0] row_sum;
    bit [23:0] row_sq_sum;
    int unsigned load_pos;
    bit        frame_done;
    bit [7:0]  win_reg;
    bit [9:0]  k_reg;
    bit [8:0]  width_reg;
    bit [8:0]  height_reg;

    pixel_verdict_t expected_verdicts[$];
    int  error_count;
    int  quiet_cycles;
    bit  no_idle;
    bit  hold_req;
    int  items_sent;

    // Clock: 8 ns period.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int unsigned cur_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAXW) return MAXW;
        return width_reg;
    endfunction

    function automatic int unsigned cur_height();
        if (height_reg == 0) return 1;
        if (height_reg > MAXH) return MAXH;
        return height_reg;
    endfunction

    function automatic void restart_load();
        load_pos   = 0;
        row_sum    = 0;
        row_sq_sum = 0;
        frame_done = 0;
    endfunction

    function automatic longint unsigned window_total(bit is_square, int unsigned y0,
                                                     int unsigned x0, int unsigned y1,
                                                     int unsigned x1);
        longint unsigned acc;
        acc = is_square ? shadow_sq_img[y1*MAXW+x1] : shadow_sum_img[y1*MAXW+x1];
        if (y0 > 0)
            acc -= is_square ? shadow_sq_img[(y0-1)*MAXW+x1] : shadow_sum_img[(y0-1)*MAXW+x1];
        if (x0 > 0)
            acc -= is_square ? shadow_sq_img[y1*MAXW+x0-1] : shadow_sum_img[y1*MAXW+x0-1];
        if (y0 > 0 && x0 > 0)
            acc += is_square ? shadow_sq_img[(y0-1)*MAXW+x0-1]
                             : shadow_sum_img[(y0-1)*MAXW+x0-1];
        return acc;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Advance the shadow state by one accepted transaction; queue a query's verdict.
    function automatic void binarize_predict(logic cmd, bit [7:0] pv, bit [7:0] qr,
                                             bit [7:0] qc);
        int unsigned w, h, r, c, idx, half, x0, y0, x1, y1;
        longint unsigned area, s, q, mq, sd, num, den, var_q, f, p;
        pixel_verdict_t v;
        w = cur_width();
        h = cur_height();
        if (cmd == CMD_LOAD)
        begin
            if (frame_done)
                restart_load();
            r = load_pos / w;
            c = load_pos % w;
            if (r >= h)
            begin
                restart_load();
                r = 0;
                c = 0;
            end
            if (c == 0)
            begin
                row_sum    = 0;
                row_sq_sum = 0;
            end
            row_sum    += pv;
            row_sq_sum += pv * pv;
            idx = r * MAXW + c;
            shadow_pixels[idx]  = pv;
            shadow_sum_img[idx] = (r > 0 ? shadow_sum_img[idx-MAXW] : 24'd0) + row_sum;
            shadow_sq_img[idx]  = (r > 0 ? shadow_sq_img[idx-MAXW] : 32'd0) + row_sq_sum;
            load_pos++;
            if (load_pos >= w * h)
                frame_done = 1;
            return;
        end
        v.binary_value = PIX_BLACK;
        if (qr >= h || qc >= w)
            v.status = STATUS_OUTSIDE;
        else if (!frame_done)
            v.status = STATUS_NOT_LOADED;
        else
        begin
            v.status = STATUS_OK;
            half = win_reg >> 1;
            x0   = qc > half ? qc - half : 0;
            y0   = qr > half ? qr - half : 0;
            x1   = qc + half < w - 1 ? qc + half : w - 1;
            y1   = qr + half < h - 1 ? qr + half : h - 1;
            area = longint'(x1 - x0 + 1) * longint'(y1 - y0 + 1);
            s    = window_total(0, y0, x0, y1, x1);
            q    = window_total(1, y0, x0, y1, x1);
            mq   = (s * 256) / area;
            if (area <= 1)
                sd = 0;
            else
            begin
                num   = area * q - s * s;
                den   = area * (area - 1);
                var_q = (num / den) * 65536 + ((num % den) * 65536) / den;
                sd    = floor_root(var_q);
            end
            f = longint'(F_ONE) - longint'(k_reg) * 32768 + longint'(k_reg) * sd;
            p = longint'(shadow_pixels[qr*MAXW+qc]) << 33;
            v.binary_value = (p < mq * f) ? PIX_BLACK : PIX_WHITE;
        end
        expected_verdicts.push_back(v);
    endfunction

    // Offer one transaction after a random gap, none with no_idle; valid stays high without a gap.
    task automatic send_item(logic cmd, bit [7:0] pv, bit [7:0] qr, bit [7:0] qc);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid       = 1'b1;
        in_ch.cmd         = cmd;
        in_ch.pixel_value = pv;
        in_ch.query_row   = qr;
        in_ch.query_col   = qc;
        do @(posedge clk); while (!in_ch.ready);
        binarize_predict(cmd, pv, qr, qc);
        items_sent++;
    endtask

    task automatic send_load(bit [7:0] pv);
        send_item(CMD_LOAD, pv, $urandom, $urandom);
    endtask

    task automatic send_query(bit [7:0] qr, bit [7:0] qc);
        send_item(CMD_QUERY, $urandom, qr, qc);
    endtask

    // Drop valid, wait for every verdict, then idle through the SETTLE margin.
    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_WINDOW: win_reg = val[7:0];
            REG_K:      k_reg = val;
            REG_WIDTH:
            begin
                width_reg = val[8:0];
                restart_load();
            end
            REG_HEIGHT:
            begin
                height_reg = val[8:0];
                restart_load();
            end
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Load a whole frame; pixels polarized toward black and white if asked.
    task automatic load_frame(bit extremes);
        int n;
        n = cur_width() * cur_height();
        for (int i = 0; i < n; i++)
            send_load(extremes ? ($urandom_range(0, 1) ? 8'd255 : 8'd0) : 8'($urandom));
    endtask

    task automatic test_reset_defaults();
        // Reset frame is 256x256 and empty: in-range queries are early.
        send_query(0, 0);
        send_query(255, 255);
        drain();
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 3);
        send_query(1, 1);
        for (int i = 0; i < 12; i++)
            send_load((i % 3 == 0) ? 8'd255 : (i % 3 == 1) ? 8'd0 : 8'd128);
        send_query(0, 0);
        send_query(2, 3);
        send_query(1, 2);
        send_query(3, 0);
        send_query(0, 4);
        send_query(255, 255);
        drain();
    endtask

    task automatic test_window_extremes();
        write_reg(REG_WINDOW, 0);
        send_query(1, 1);
        send_query(2, 3);
        drain();
        write_reg(REG_WINDOW, 1);
        write_reg(REG_K, 1);
        send_query(0, 0);
        send_query(1, 2);
        drain();
        write_reg(REG_WINDOW, 255);
        write_reg(REG_K, 1023);
        send_query(0, 1);
        send_query(2, 2);
        drain();
        write_reg(REG_WINDOW, 2);
        send_query(1, 1);
        send_query(2, 0);
        // Unknown register index changes nothing.
        drain();
        write_reg(8'd7, 10'h3FF);
        send_query(1, 3);
        drain();
    endtask

    task automatic test_size_extremes();
        write_reg(REG_WINDOW, 6);
        write_reg(REG_K, 307);
        // Width zero acts as one column.
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 3);
        load_frame(0);
        send_query(0, 0);
        send_query(2, 0);
        send_query(1, 1);
        drain();
        // Width above the maximum saturates.
        write_reg(REG_WIDTH, 511);
        write_reg(REG_HEIGHT, 1);
        load_frame(0);
        send_query(0, 255);
        send_query(0, 0);
        send_query(1, 128);
        drain();
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 256);
        load_frame(1);
        send_query(255, 0);
        send_query(0, 0);
        drain();
        // Height zero acts as one row; 1x1 image has a one-pixel window.
        write_reg(REG_HEIGHT, 0);
        send_load(8'd200);
        send_query(0, 0);
        send_query(1, 0);
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 4);
        write_reg(REG_WINDOW, 3);
        load_frame(0);
        drain();
        no_idle  = 1;
        @(negedge clk);
        hold_req = 1'b1;
        // Keep offering queries while the receiver is held off.
        for (int i = 0; i < 30; i++)
            send_query($urandom_range(0, 4), $urandom_range(0, 4));
        no_idle = 0;
        drain();
    endtask

    task automatic test_random();
        int unsigned w, h, nq;
        while (items_sent < 1700)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                w = $urandom_range(8, 16);
                h = $urandom_range(8, 16);
            end
            else
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 8);
            end
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_WINDOW, $urandom);
            else
                write_reg(REG_WINDOW, $urandom_range(0, 9));
            write_reg(REG_K, $urandom_range(0, 3) == 0 ? $urandom_range(1, 1023)
                                                       : $urandom_range(150, 500));
            // An early query now and then while loading.
            for (int i = 0; i < w * h; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_query($urandom_range(0, h - 1), $urandom_range(0, w - 1));
                send_load($urandom_range(0, 2) == 0 ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                                    : 8'($urandom));
            end
            nq = $urandom_range(8, 24);
            for (int i = 0; i < nq; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_query($urandom, $urandom);
                else
                    send_query($urandom_range(0, h - 1), $urandom_range(0, w - 1));
            end
            // Broken sequence: restart the frame and reload it, one query inside and one after.
            if ($urandom_range(0, 4) == 0)
            begin
                send_load($urandom);
                send_query(0, 0);
                for (int i = 1; i < w * h; i++)
                    send_load($urandom);
                send_query($urandom_range(0, h - 1), $urandom_range(0, w - 1));
            end
            drain();
        end
        no_idle = 0;
    endtask

    // Result receiver: random stalls, one long hold on request.
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req     = 1'b0;
                out_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    // Compare each result transaction with the oldest expected verdict.
    always @(posedge clk)
    begin
        pixel_verdict_t exp_v;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result binary_value %0d status %0d",
                         $time, out_ch.binary_value, out_ch.status);
                error_count++;
            end
            else
            begin
                exp_v = expected_verdicts.pop_front();
                if (out_ch.binary_value !== exp_v.binary_value)
                begin
                    $display("%0t: binary_value expected %0d actual %0d",
                             $time, exp_v.binary_value, out_ch.binary_value);
                    error_count++;
                end
                if (out_ch.status !== exp_v.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_v.status, out_ch.status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no channel moves a transaction for too long.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_LOAD;
        in_ch.pixel_value = '0;
        in_ch.query_row   = '0;
        in_ch.query_col   = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        error_count       = 0;
        quiet_cycles      = 0;
        no_idle           = 0;
        hold_req          = 0;
        items_sent        = 0;
        win_reg           = WINDOW_RESET;
        k_reg             = K_RESET;
        width_reg         = SIZE_RESET;
        height_reg        = SIZE_RESET;
        restart_load();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_window_extremes();
        test_size_extremes();
        test_backpressure();
        test_random();

        drain();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
